[sv/sjfs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the job slot table scheduler.
// No dependencies; imported by every module of the block.
package sjfs_pkg;

  localparam int unsigned SIZE_W     = 10;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned SLOT_OUT_W = 5;

  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_SERVE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ZERO  = 2'd3
  } status_e;

  typedef struct packed {
    logic              operation;
    logic [SIZE_W-1:0] job_size;
    logic [TIME_W-1:0] time_now;
  } in_item_t;

  typedef struct packed {
    status_e               status;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [SIZE_W-1:0]     served_size;
    logic [TIME_W-1:0]     wait_time;
    logic [CNT_W-1:0]      jobs_served;
    logic [SUM_W-1:0]      wait_total;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] arrival;
  } slot_entry_t;

  typedef struct packed {
    logic              fire;
    logic [TIME_W-1:0] wait_time;
  } stats_upd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] total;
  } stats_t;

endpackage

[sv/sjfs_slot_mem.sv]
`timescale 1ns / 1ps
// Slot table storage: job size and arrival time per slot, one write and
// one registered read port. Depends on sjfs_pkg.
module sjfs_slot_mem #(
  parameter int unsigned SLOTS = 32,
  localparam int unsigned IW = $clog2(SLOTS)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [IW-1:0]        waddr_i,
  input  sjfs_pkg::slot_entry_t wdata_i,
  input  logic                 re_i,
  input  logic [IW-1:0]        raddr_i,
  output sjfs_pkg::slot_entry_t rdata_o
);
  import sjfs_pkg::*;

  slot_entry_t mem_q [SLOTS];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/sjfs_stats.sv]
`timescale 1ns / 1ps
// Saturating totals of jobs served and of wait time.
// Depends on sjfs_pkg; exposes the post-update totals to the controller.
module sjfs_stats (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sjfs_pkg::stats_upd_t upd_i,
  output sjfs_pkg::stats_t     next_o
);
  import sjfs_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] total_q, total_d;
  logic [SUM_W:0]   sum_wide;

  always_comb begin
    sum_wide = {1'b0, total_q} + (SUM_W + 1)'(upd_i.wait_time);
    count_d  = count_q;
    total_d  = total_q;
    if (upd_i.fire) begin
      count_d = (count_q == '1) ? count_q : count_q + 1'b1;
      total_d = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
    end else begin
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  assign next_o.count = count_d;
  assign next_o.total = total_d;

endmodule

[sv/sjfs_ctrl.sv]
`timescale 1ns / 1ps
// Scan sequencer: occupancy bits, slot table scan, candidate selection,
// write-back and output register. Depends on sjfs_pkg.
module sjfs_ctrl #(
  parameter int unsigned SLOTS = 32,
  localparam int unsigned IW = $clog2(SLOTS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  mode_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sjfs_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sjfs_pkg::out_item_t   out_data_o,
  output logic                  mem_we_o,
  output logic [IW-1:0]         mem_waddr_o,
  output sjfs_pkg::slot_entry_t mem_wdata_o,
  output logic                  mem_re_o,
  output logic [IW-1:0]         mem_raddr_o,
  input  sjfs_pkg::slot_entry_t mem_rdata_i,
  output sjfs_pkg::stats_upd_t  stats_upd_o,
  input  sjfs_pkg::stats_t      stats_next_i
);
  import sjfs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_e;

  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  state_e            state_q;
  in_item_t          item_q;
  logic [IW-1:0]     addr_q;
  logic [IW-1:0]     cnt_q;
  logic              eval_v_q;
  logic [IW-1:0]     eval_idx_q;
  logic              found_q;
  logic [IW-1:0]     scan_ptr_q;
  logic [SLOTS-1:0]  occ_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [IW-1:0]     best_idx_q;
  logic [SIZE_W-1:0] best_size_q;
  logic [TIME_W-1:0] best_arr_q;

  logic              in_accept;
  logic              done_fire;
  logic              is_serve;
  logic              zero_size;
  logic              occ_bit;
  logic              take;
  logic              ok_submit;
  logic              ok_serve;
  logic [TIME_W-1:0] wait_val;
  logic [IW-1:0]     addr_next;
  out_item_t         result;

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign done_fire = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign is_serve  = (item_q.operation == OP_SERVE);
  assign zero_size = (item_q.job_size == '0);
  assign occ_bit   = occ_q[eval_idx_q];
  assign ok_submit = !is_serve && !zero_size && found_q;
  assign ok_serve  = is_serve && found_q;
  assign wait_val  = item_q.time_now - best_arr_q;
  assign addr_next = (addr_q == LAST_IDX) ? '0 : addr_q + 1'b1;

  always_comb begin
    if (!is_serve) begin
      take = !occ_bit && !found_q;
    end else begin
      take = occ_bit && (!found_q || (mode_i && (mem_rdata_i.size < best_size_q)));
    end
  end

  always_comb begin
    result = '0;
    if (!is_serve) begin
      if (zero_size) begin
        result.status = ST_ZERO;
      end else if (found_q) begin
        result.status = ST_OK;
      end else begin
        result.status = ST_FULL;
      end
    end else begin
      result.status = found_q ? ST_OK : ST_EMPTY;
    end
    if (ok_submit || ok_serve) begin
      result.slot_index = SLOT_OUT_W'(best_idx_q);
    end
    if (ok_serve) begin
      result.served_size = best_size_q;
      result.wait_time   = wait_val;
    end
    result.jobs_served = stats_next_i.count;
    result.wait_total  = stats_next_i.total;
  end

  assign mem_re_o            = (state_q == S_SCAN);
  assign mem_raddr_o         = addr_q;
  assign mem_we_o            = done_fire && ok_submit;
  assign mem_waddr_o         = best_idx_q;
  assign mem_wdata_o.size    = item_q.job_size;
  assign mem_wdata_o.arrival = item_q.time_now;
  assign stats_upd_o.fire      = done_fire && ok_serve;
  assign stats_upd_o.wait_time = wait_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      addr_q      <= '0;
      cnt_q       <= '0;
      eval_v_q    <= 1'b0;
      eval_idx_q  <= '0;
      found_q     <= 1'b0;
      scan_ptr_q  <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      eval_v_q   <= (state_q == S_SCAN);
      eval_idx_q <= addr_q;
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (eval_v_q && take) begin
        found_q <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            found_q <= 1'b0;
            cnt_q   <= '0;
            if (in_data_i.operation == OP_SERVE && !mode_i) begin
              addr_q <= scan_ptr_q;
            end else begin
              addr_q <= '0;
            end
            if (in_data_i.operation == OP_SUBMIT && in_data_i.job_size == '0) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          addr_q <= addr_next;
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == LAST_IDX) begin
            state_q <= S_LAST;
          end
        end
        S_LAST: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (done_fire) begin
            out_q   <= result;
            state_q <= S_IDLE;
            if (ok_submit) begin
              occ_q[best_idx_q] <= 1'b1;
            end
            if (ok_serve) begin
              occ_q[best_idx_q] <= 1'b0;
              if (!mode_i) begin
                scan_ptr_q <= (best_idx_q == LAST_IDX) ? '0 : best_idx_q + 1'b1;
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    if (eval_v_q && take) begin
      best_idx_q  <= eval_idx_q;
      best_size_q <= mem_rdata_i.size;
      best_arr_q  <= mem_rdata_i.arrival;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/job_slot_table_sjf_scheduler_top.sv]
`timescale 1ns / 1ps
// Job slot table scheduler, shortest-first or circular order service.
// One item is handled at a time: the table scan does one memory read per cycle, and a
// zero size submit skips the scan. The next item is taken while a result waits in the
// output register.
// Reset: asynchronous, active low; empties every slot, clears totals and scan pointer.
module job_slot_table_sjf_scheduler_top #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sjfs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sjfs_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);
  import sjfs_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);

  logic          mode_q;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  slot_entry_t   mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  slot_entry_t   mem_rdata;
  stats_upd_t    stats_upd;
  stats_t        stats_next;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  sjfs_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sjfs_stats u_stats (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (stats_upd),
    .next_o (stats_next)
  );

  sjfs_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .stats_upd_o  (stats_upd),
    .stats_next_i (stats_next)
  );

endmodule

[sv/sjfs_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the job slot table scheduler, bound to the top level.
// Depends on sjfs_pkg and job_slot_table_sjf_scheduler_top.
module sjfs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sjfs_pkg::out_item_t out_data_o
);
  import sjfs_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous transaction in flight");

  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.slot_index == '0 && out_data_o.served_size == '0 &&
      out_data_o.wait_time == '0)
    else $error("failed transaction carries nonzero slot or serve fields");

  a_submit_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_OK && out_data_o.served_size == '0 |->
      out_data_o.wait_time == '0)
    else $error("submit result carries a wait time");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

endmodule

bind job_slot_table_sjf_scheduler_top sjfs_checker u_sjfs_checker (.*);

[tb/sjfs_dispatch_checker.sv]
`timescale 1ns / 1ps
// Checker for the job slot table scheduler: tracks slot occupancy, predicts each result.
// Depends on sjfs_pkg; watches the item, result and mode-write channels of the top level.
module sjfs_dispatch_checker #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  sjfs_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  sjfs_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_data_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         outstanding_o
);
  import sjfs_pkg::*;

  localparam logic [CNT_W-1:0] COUNT_CEIL = '1;
  localparam logic [SUM_W-1:0] SUM_CEIL   = '1;

  logic              shortest_first;
  logic [SIZE_W-1:0] job_size_q [SLOTS];
  logic [TIME_W-1:0] arrival_q [SLOTS];
  int unsigned       scan_ptr;
  logic [CNT_W-1:0]  served_jobs;
  logic [SUM_W-1:0]  wait_acc;
  out_item_t         awaited_results [$];

  function automatic out_item_t schedule_item(in_item_t job);
    out_item_t         res;
    int                pick;
    int unsigned       idx;
    int unsigned       i;
    logic [TIME_W-1:0] delay;
    logic [SUM_W:0]    sum_ext;
    res = '0;
    res.status = ST_OK;
    pick = -1;
    if (job.operation == OP_SUBMIT) begin
      if (job.job_size == '0) begin
        res.status = ST_ZERO;
      end else begin
        for (i = 0; i < SLOTS; i++) begin
          if (pick < 0 && job_size_q[i] == '0) pick = i;
        end
        if (pick < 0) begin
          res.status = ST_FULL;
        end else begin
          job_size_q[pick] = job.job_size;
          arrival_q[pick] = job.time_now;
          res.slot_index = pick[SLOT_OUT_W-1:0];
        end
      end
    end else begin
      for (i = 0; i < SLOTS; i++) begin
        if (shortest_first) begin
          if (job_size_q[i] != '0 && (pick < 0 || job_size_q[i] < job_size_q[pick])) pick = i;
        end else begin
          idx = (scan_ptr + i) % SLOTS;
          if (pick < 0 && job_size_q[idx] != '0) pick = idx;
        end
      end
      if (pick < 0) begin
        res.status = ST_EMPTY;
      end else begin
        delay = job.time_now - arrival_q[pick];
        res.slot_index = pick[SLOT_OUT_W-1:0];
        res.served_size = job_size_q[pick];
        res.wait_time = delay;
        job_size_q[pick] = '0;
        if (!shortest_first) scan_ptr = (pick + 1) % SLOTS;
        if (served_jobs != COUNT_CEIL) served_jobs = served_jobs + 1'b1;
        sum_ext = {1'b0, wait_acc} + delay;
        wait_acc = (sum_ext > {1'b0, SUM_CEIL}) ? SUM_CEIL : sum_ext[SUM_W-1:0];
      end
    end
    res.jobs_served = served_jobs;
    res.wait_total = wait_acc;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      shortest_first = 1'b0;
      scan_ptr = 0;
      served_jobs = '0;
      wait_acc = '0;
      for (int unsigned k = 0; k < SLOTS; k++) begin
        job_size_q[k] = '0;
        arrival_q[k] = '0;
      end
      awaited_results.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) shortest_first = cfg_data_i;
      if (in_valid_i && !in_stall_i) awaited_results.push_back(schedule_item(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with no pending expectation");
          mismatch_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data_i.status);
            mismatch_count_o++;
          end
          if (out_data_i.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, actual %0d", want.slot_index,
                   out_data_i.slot_index);
            mismatch_count_o++;
          end
          if (out_data_i.served_size !== want.served_size) begin
            $error("served_size: expected %0d, actual %0d", want.served_size,
                   out_data_i.served_size);
            mismatch_count_o++;
          end
          if (out_data_i.wait_time !== want.wait_time) begin
            $error("wait_time: expected %0h, actual %0h", want.wait_time, out_data_i.wait_time);
            mismatch_count_o++;
          end
          if (out_data_i.jobs_served !== want.jobs_served) begin
            $error("jobs_served: expected %0d, actual %0d", want.jobs_served,
                   out_data_i.jobs_served);
            mismatch_count_o++;
          end
          if (out_data_i.wait_total !== want.wait_total) begin
            $error("wait_total: expected %0h, actual %0h", want.wait_total,
                   out_data_i.wait_total);
            mismatch_count_o++;
          end
        end
      end
    end
    outstanding_o = awaited_results.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the job slot table scheduler: directed and random job traffic.
// Depends on sjfs_pkg, job_slot_table_sjf_scheduler_top and sjfs_dispatch_checker.
module tb;
  import sjfs_pkg::*;

  localparam int unsigned SLOTS          = 32;
  localparam int unsigned RANDOM_JOBS    = 1500;
  localparam int unsigned QUIET_TAIL     = 150;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          send_calm = 1'b0;

  job_slot_table_sjf_scheduler_top #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  sjfs_dispatch_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_data_i      (out_data_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("job_slot_table_sjf_scheduler_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver backpressure: random bursts, with calm windows
  initial begin : stall_gen
    int unsigned burst;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 63) == 0) begin
        repeat ($urandom_range(50, 400)) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 17);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_job(input logic op, input logic [SIZE_W-1:0] sz,
                          input logic [TIME_W-1:0] at);
    int unsigned gap;
    gap = 0;
    if (!quiet && !send_calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{operation: op, job_size: sz, time_now: at};
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  task automatic write_mode(input logic sjf);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= sjf;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [5:0]        phase_modes;
    logic              op;
    logic [SIZE_W-1:0] sz;
    logic [TIME_W-1:0] clock_ms;
    int unsigned       fill_pct;
    int unsigned       seg_left;
    int unsigned       pick;
    int unsigned       n;
    phase_modes = 6'b010110;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // circular order from reset
    send_job(OP_SERVE, 10'd0, 32'd100);
    send_job(OP_SUBMIT, 10'd0, 32'd100);
    send_job(OP_SUBMIT, 10'd1023, 32'hFFFF_FFF0);
    send_job(OP_SUBMIT, 10'd1, 32'hFFFF_FFFF);
    send_job(OP_SUBMIT, 10'd1, 32'd0);
    send_job(OP_SUBMIT, 10'd512, 32'd5);
    send_job(OP_SERVE, 10'd1023, 32'h10);
    send_job(OP_SUBMIT, 10'd7, 32'h1000);
    send_job(OP_SERVE, 10'd0, 32'h20);
    send_job(OP_SERVE, 10'd0, 32'h30);
    send_job(OP_SERVE, 10'd0, 32'h40);
    send_job(OP_SERVE, 10'd0, 32'h0FFF);
    send_job(OP_SERVE, 10'd0, 32'h50);

    // shortest first, ties and extremes
    write_mode(1'b1);
    send_job(OP_SUBMIT, 10'd5, 32'd1000);
    send_job(OP_SUBMIT, 10'd3, 32'd1001);
    send_job(OP_SUBMIT, 10'd3, 32'd1002);
    send_job(OP_SUBMIT, 10'd1023, 32'd1003);
    send_job(OP_SUBMIT, 10'd9, 32'd1004);
    send_job(OP_SUBMIT, 10'd0, 32'd1005);
    repeat (5) send_job(OP_SERVE, 10'd0, 32'hFFFF_0000);
    send_job(OP_SERVE, 10'd0, 32'hFFFF_0001);

    clock_ms = $urandom();
    n = 0;
    for (int p = 0; p < 6; p++) begin
      write_mode(phase_modes[p]);
      // vary the submit share per segment to sweep fill levels
      seg_left = 0;
      fill_pct = 50;
      for (int k = 0; k < RANDOM_JOBS / 6; k++) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 60);
          pick = $urandom_range(0, 3);
          fill_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : (pick == 2) ? 75 : 97;
          send_calm = ($urandom_range(0, 3) == 0);
        end
        seg_left--;
        if (n + QUIET_TAIL >= RANDOM_JOBS) quiet = 1'b1;
        op = ($urandom_range(1, 100) <= fill_pct) ? OP_SUBMIT : OP_SERVE;
        pick = $urandom_range(0, 15);
        if (pick == 0) sz = '0;
        else if (pick < 5) sz = SIZE_W'($urandom_range(1, 4));
        else if (pick < 7) sz = '1;
        else sz = SIZE_W'($urandom_range(1, 1023));
        if ($urandom_range(0, 15) == 0) clock_ms = $urandom();
        else clock_ms = clock_ms + $urandom_range(0, 2000);
        send_job(op, sz, clock_ms);
        n++;
      end
    end
    in_valid_i <= 1'b0;

    do @(negedge clk_i); while (outstanding != 0);
    repeat (SLOTS + 8) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("job_slot_table_sjf_scheduler_top verification clean");
    end else begin
      $display("job_slot_table_sjf_scheduler_top verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/sjfs_pkg.sv
sv/sjfs_slot_mem.sv
sv/sjfs_stats.sv
sv/sjfs_ctrl.sv
sv/job_slot_table_sjf_scheduler_top.sv
sv/sjfs_checker.sv
tb/sjfs_dispatch_checker.sv
tb/tb.sv
